// ===== hw/rtl/lvfo_pkg.sv =====
`default_nettype none

package lvfo_pkg;

   // Largest number of classes in one voxel's count vector.
   localparam int MAX_CLASSES = 256;

   // Reset values of the configuration registers.
   localparam logic [7:0] RATERS_RESET = 8'd2;
   localparam logic [8:0] CLASSES_RESET = 9'd3;

   // The overlap ratio is a Q16 value: one is 2^16.
   localparam int OVERLAP_FRAC = 16;
   localparam logic [16:0] OVERLAP_ONE = 17'h10000;

   // The divider makes one quotient bit per cycle.
   localparam int DIV_STEPS = OVERLAP_FRAC;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Global totals saturate at the top of their range.
   localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

   // Depth of the voxel queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_NUM_RATERS   = 2'd0,
      CSR_NUM_CLASSES  = 2'd1,
      CSR_CLEAR_TOTALS = 2'd2
   } csr_index_type;

   // Live configuration seen by the front part.
   typedef struct packed {
      logic [7:0] raters;
      logic [8:0] classes;
   } cfg_type;

   // One finished voxel as handed from the front part to the back part.
   typedef struct packed {
      logic        found;
      logic [7:0]  index;
      logic [22:0] inter;
      logic [22:0] union_sum;
   } voxel_type;

   // One result word.
   typedef struct packed {
      logic        majority_valid;
      logic [7:0]  majority_index;
      logic [22:0] voxel_intersection;
      logic [22:0] voxel_union;
      logic [16:0] voxel_overlap;
      logic [47:0] total_intersection;
      logic [47:0] total_union;
   } result_type;

   // Back part sequencer states.
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DONE
   } back_state_type;

   // Number of rater pairs among k raters: k choose two.
   function automatic logic [14:0] pairs(input logic [7:0] k);
      logic [15:0] prod;
      prod = 16'(k) * 16'(k - 8'd1);
      return prod[15:1];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lvfo_front.sv =====
`default_nettype none

module lvfo_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lvfo_pkg::cfg_type cfg,
   input  wire logic              accept,
   input  wire logic [7:0]        vote_count,
   output lvfo_pkg::voxel_type    push_word,
   output logic                   push
);

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  best_count_ff, best_count_in;
   logic [7:0]  best_class_ff, best_class_in;
   logic        best_found_ff, best_found_in;
   logic [22:0] inter_ff, inter_in;
   logic [22:0] union_ff, union_in;

   logic [7:0]  vote;
   logic [8:0]  classes_eff;
   logic [14:0] union_term;
   logic        better;
   logic        last;
   logic [22:0] inter_sum;
   logic [22:0] union_sum;

   // Clamp the count to the rater count and the class count to its legal range.
   always_comb begin
      vote = (vote_count > cfg.raters) ? cfg.raters : vote_count;
      if (cfg.classes == 9'd0) begin
         classes_eff = 9'd1;
      end else if (cfg.classes > 9'(lvfo_pkg::MAX_CLASSES)) begin
         classes_eff = 9'(lvfo_pkg::MAX_CLASSES);
      end else begin
         classes_eff = cfg.classes;
      end
   end

   // Pair counts for this class and the running sums that include it.
   always_comb begin
      union_term = lvfo_pkg::pairs(cfg.raters) - lvfo_pkg::pairs(cfg.raters - vote);
      inter_sum  = inter_ff + 23'(lvfo_pkg::pairs(vote));
      union_sum  = union_ff + 23'(union_term);
      better     = vote > best_count_ff;
      last       = ({1'b0, pos_ff} + 9'd1) >= classes_eff;
   end

   // Hand the finished voxel to the queue on its last class.
   always_comb begin
      push                = accept && last;
      push_word.found     = best_found_ff || better;
      push_word.index     = better ? pos_ff : best_class_ff;
      push_word.inter     = inter_sum;
      push_word.union_sum = union_sum;
   end

   // Update the running voxel state, starting over after the last class.
   always_comb begin
      pos_in        = pos_ff;
      best_count_in = best_count_ff;
      best_class_in = best_class_ff;
      best_found_in = best_found_ff;
      inter_in      = inter_ff;
      union_in      = union_ff;
      if (accept) begin
         if (last) begin
            pos_in        = 8'd0;
            best_count_in = 8'd0;
            best_class_in = 8'd0;
            best_found_in = 1'b0;
            inter_in      = 23'd0;
            union_in      = 23'd0;
         end else begin
            pos_in   = pos_ff + 8'd1;
            inter_in = inter_sum;
            union_in = union_sum;
            if (better) begin
               best_count_in = vote;
               best_class_in = pos_ff;
               best_found_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 8'd0;
         best_count_ff <= 8'd0;
         best_class_ff <= 8'd0;
         best_found_ff <= 1'b0;
         inter_ff      <= 23'd0;
         union_ff      <= 23'd0;
      end else begin
         pos_ff        <= pos_in;
         best_count_ff <= best_count_in;
         best_class_ff <= best_class_in;
         best_found_ff <= best_found_in;
         inter_ff      <= inter_in;
         union_ff      <= union_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lvfo_queue.sv =====
`default_nettype none

module lvfo_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire lvfo_pkg::voxel_type push_word,
   input  wire logic                pop,
   output lvfo_pkg::voxel_type      head,
   output logic                     empty,
   output logic                     full
);

   lvfo_pkg::voxel_type entry_ff [lvfo_pkg::QUEUE_DEPTH];

   logic [lvfo_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lvfo_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lvfo_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   always_comb begin
      empty   = count_ff == lvfo_pkg::QUEUE_CNT_W'(0);
      full    = count_ff == lvfo_pkg::QUEUE_CNT_W'(lvfo_pkg::QUEUE_DEPTH);
      head    = entry_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
   end

   // Pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == lvfo_pkg::QUEUE_PTR_W'(lvfo_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == lvfo_pkg::QUEUE_PTR_W'(lvfo_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + lvfo_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - lvfo_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lvfo_back.sv =====
`default_nettype none

module lvfo_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire lvfo_pkg::voxel_type q_head,
   output logic                     q_pop,
   input  wire logic                clear_totals,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output lvfo_pkg::result_type     rsp_word
);

   lvfo_pkg::back_state_type state_ff, state_in;

   lvfo_pkg::voxel_type              cur_ff;
   logic [22:0]                      rem_ff;
   logic [16:0]                      ov_ff;
   logic [lvfo_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [47:0]                      total_i_ff, total_i_in;
   logic [47:0]                      total_u_ff, total_u_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   lvfo_pkg::result_type             rsp_word_ff;

   logic        div_step;
   logic        load_out;
   logic        need_div;
   logic        last_step;
   logic [23:0] rem_shift;
   logic        rem_ge;
   logic [48:0] sum_i;
   logic [48:0] sum_u;

   // A division runs only when the union is nonzero and the intersection lies below it.
   always_comb begin
      need_div  = (q_head.union_sum != 23'd0) && (q_head.inter < q_head.union_sum);
      last_step = cnt_ff == lvfo_pkg::DIV_CNT_W'(lvfo_pkg::DIV_STEPS - 1);
      rem_shift = {rem_ff, 1'b0};
      rem_ge    = rem_shift >= {1'b0, cur_ff.union_sum};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lvfo_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               state_in = need_div ? lvfo_pkg::BACK_DIVIDE : lvfo_pkg::BACK_DONE;
            end
         end
         lvfo_pkg::BACK_DIVIDE: begin
            if (last_step) begin
               state_in = lvfo_pkg::BACK_DONE;
            end
         end
         lvfo_pkg::BACK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = lvfo_pkg::BACK_IDLE;
            end
         end
         default: state_in = lvfo_pkg::BACK_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      q_pop    = 1'b0;
      div_step = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         lvfo_pkg::BACK_IDLE:   q_pop    = !q_empty;
         lvfo_pkg::BACK_DIVIDE: div_step = 1'b1;
         lvfo_pkg::BACK_DONE:   load_out = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // Saturating global totals, updated when a voxel is taken from the queue; a clear write wins.
   always_comb begin
      sum_i      = {1'b0, total_i_ff} + 49'(q_head.inter);
      sum_u      = {1'b0, total_u_ff} + 49'(q_head.union_sum);
      total_i_in = total_i_ff;
      total_u_in = total_u_ff;
      if (clear_totals) begin
         total_i_in = 48'd0;
         total_u_in = 48'd0;
      end else if (q_pop) begin
         total_i_in = sum_i[48] ? lvfo_pkg::TOTAL_MAX : sum_i[47:0];
         total_u_in = sum_u[48] ? lvfo_pkg::TOTAL_MAX : sum_u[47:0];
      end
   end

   // The output register takes a new word when it is empty or being drained.
   always_comb begin
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lvfo_pkg::BACK_IDLE;
         total_i_ff   <= 48'd0;
         total_u_ff   <= 48'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_i_ff   <= total_i_in;
         total_u_ff   <= total_u_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Restoring divider: one quotient bit of I * 2^16 / U per cycle.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
         rem_ff <= q_head.inter;
         cnt_ff <= '0;
         if (q_head.union_sum == 23'd0) begin
            ov_ff <= 17'd0;
         end else if (!need_div) begin
            ov_ff <= lvfo_pkg::OVERLAP_ONE;
         end else begin
            ov_ff <= 17'd0;
         end
      end else if (div_step) begin
         rem_ff <= rem_ge ? 23'(rem_shift - {1'b0, cur_ff.union_sum}) : rem_shift[22:0];
         ov_ff  <= {ov_ff[15:0], rem_ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_word_ff.majority_valid     <= cur_ff.found;
         rsp_word_ff.majority_index     <= cur_ff.found ? cur_ff.index : 8'd0;
         rsp_word_ff.voxel_intersection <= cur_ff.inter;
         rsp_word_ff.voxel_union        <= cur_ff.union_sum;
         rsp_word_ff.voxel_overlap      <= ov_ff;
         rsp_word_ff.total_intersection <= total_i_ff;
         rsp_word_ff.total_union        <= total_u_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/label_vote_fusion_overlap.sv =====
// A voxel's last class word pushes it into a two-voxel queue; the back part pops it when idle,
// runs the bit-serial divider unless the overlap needs no division (zero union, or intersection
// equal to union), and loads the result word into the output register. Input: one class word per
// cycle while the queue has room; the front part takes the next voxel while the back part works.
// Reset is synchronous: it clears the voxel state, the queue, the totals and the output,
// and loads num_raters = 2 and num_classes = 3; no clearing pass is needed.
`default_nettype none

module label_vote_fusion_overlap (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_vote_count,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_majority_valid,
   output logic [7:0]       rsp_majority_index,
   output logic [22:0]      rsp_voxel_intersection,
   output logic [22:0]      rsp_voxel_union,
   output logic [16:0]      rsp_voxel_overlap,
   output logic [47:0]      rsp_total_intersection,
   output logic [47:0]      rsp_total_union,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   logic [7:0] num_raters_ff, num_raters_in;
   logic [8:0] num_classes_ff, num_classes_in;
   logic       clear_totals;
   logic       csr_write;

   lvfo_pkg::cfg_type    cfg;
   lvfo_pkg::voxel_type  push_word;
   lvfo_pkg::voxel_type  q_head;
   lvfo_pkg::result_type rsp_word;
   logic                 push;
   logic                 q_pop;
   logic                 q_empty;
   logic                 q_full;
   logic                 req_accept;

   // Register writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register decode.
   always_comb begin
      num_raters_in  = num_raters_ff;
      num_classes_in = num_classes_ff;
      clear_totals   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            lvfo_pkg::CSR_NUM_RATERS:   num_raters_in  = csr_data[7:0];
            lvfo_pkg::CSR_NUM_CLASSES:  num_classes_in = csr_data;
            lvfo_pkg::CSR_CLEAR_TOTALS: clear_totals   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_raters_ff  <= lvfo_pkg::RATERS_RESET;
         num_classes_ff <= lvfo_pkg::CLASSES_RESET;
      end else begin
         num_raters_ff  <= num_raters_in;
         num_classes_ff <= num_classes_in;
      end
   end

   assign cfg.raters  = num_raters_ff;
   assign cfg.classes = num_classes_ff;

   // Input is held off while the queue has no room for a voxel.
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   lvfo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (req_accept),
      .vote_count (req_vote_count),
      .push_word  (push_word),
      .push       (push)
   );

   lvfo_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   lvfo_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .clear_totals (clear_totals),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word)
   );

   assign rsp_majority_valid     = rsp_word.majority_valid;
   assign rsp_majority_index     = rsp_word.majority_index;
   assign rsp_voxel_intersection = rsp_word.voxel_intersection;
   assign rsp_voxel_union        = rsp_word.voxel_union;
   assign rsp_voxel_overlap      = rsp_word.voxel_overlap;
   assign rsp_total_intersection = rsp_word.total_intersection;
   assign rsp_total_union        = rsp_word.total_union;

`ifndef SYNTHESIS
   // A voxel is never handed to a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !q_full)
      else $error("voxel pushed into a full queue");

   // A background voxel has no pairs at all.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_majority_valid) |->
      (rsp_majority_index == 8'd0 && rsp_voxel_union == 23'd0 &&
       rsp_voxel_overlap == 17'd0))
      else $error("background result carries class or pair data");

   // Agreeing pairs are a subset of all pairs, so the ratio never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_voxel_intersection <= rsp_voxel_union &&
                     rsp_voxel_overlap <= lvfo_pkg::OVERLAP_ONE))
      else $error("overlap ratio out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/label_vote_fusion_overlap_test.sv =====
`default_nettype none

module label_vote_fusion_overlap_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lvfo_pkg::*;

   localparam int CLOCK_HALF = 4;
   localparam int RESET_CYCLES = 8;
   // Wait after the last expected word, with margin over the divider path.
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_RATERS = 255;
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_vote_count = 8'd0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_majority_valid;
   logic [7:0] rsp_majority_index;
   logic [22:0] rsp_voxel_intersection;
   logic [22:0] rsp_voxel_union;
   logic [16:0] rsp_voxel_overlap;
   logic [47:0] rsp_total_intersection;
   logic [47:0] rsp_total_union;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = 2'd0;
   logic [8:0] csr_data = 9'd0;

   label_vote_fusion_overlap dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_vote_count         (req_vote_count),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_majority_valid     (rsp_majority_valid),
      .rsp_majority_index     (rsp_majority_index),
      .rsp_voxel_intersection (rsp_voxel_intersection),
      .rsp_voxel_union        (rsp_voxel_union),
      .rsp_voxel_overlap      (rsp_voxel_overlap),
      .rsp_total_intersection (rsp_total_intersection),
      .rsp_total_union        (rsp_total_union),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   // Predictor copy of the configuration and the voxel state.
   int unsigned raters_cfg;
   int unsigned classes_cfg;
   int unsigned tally_pos;
   int unsigned lead_count;
   logic [7:0] lead_class;
   bit lead_seen;
   int unsigned agree_sum;
   int unsigned reach_sum;
   longint unsigned grand_agree;
   longint unsigned grand_reach;
   result_type fused_q[$];

   // Bookkeeping for the report.
   int mismatches = 0;
   int words_sent = 0;
   int voxels_checked = 0;
   int register_writes = 0;
   int cycle_count = 0;

   // Idling controls shared by the sender and the receiver.
   bit idle_on = 1'b1;
   int hold_request = 0;
   int hold_left = 0;
   int stall_left = 0;

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("label_vote_fusion_overlap: mismatch");
         $finish;
      end
   end

   // Gap length: mostly none, often short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   // Vote count for n raters, biased toward zero, the full count and overshoot.
   function automatic logic [7:0] vote_for(input int unsigned n);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         return 8'd0;
      end
      if (roll < 35) begin
         return 8'(n);
      end
      if (roll < 45) begin
         return 8'($urandom_range(255, n));
      end
      return 8'($urandom_range(n, 0));
   endfunction

   function automatic int unsigned pair_count(input int unsigned k);
      return (k == 0) ? 0 : (k * (k - 1)) / 2;
   endfunction

   function automatic longint unsigned add_saturated(input longint unsigned a,
                                                     input longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > 64'(TOTAL_MAX)) ? 64'(TOTAL_MAX) : s;
   endfunction

   task automatic clear_voxel();
      tally_pos = 0;
      lead_count = 0;
      lead_class = 8'd0;
      lead_seen = 1'b0;
      agree_sum = 0;
      reach_sum = 0;
   endtask

   // Fold one accepted vote word into the voxel; at the last class, queue the result.
   task automatic tally_vote(input logic [7:0] raw);
      int unsigned n;
      int unsigned nc;
      int unsigned v;
      longint unsigned wide_agree;
      longint unsigned quot;
      result_type r;
      n = (raters_cfg > MAX_RATERS) ? MAX_RATERS : raters_cfg;
      nc = classes_cfg;
      if (nc == 0) nc = 1;
      if (nc > MAX_CLASSES) nc = MAX_CLASSES;
      v = (raw > n) ? n : raw;

      // Only a strictly larger count takes over the lead.
      if (v > lead_count) begin
         lead_count = v;
         lead_class = 8'(tally_pos);
         lead_seen = 1'b1;
      end
      agree_sum = (agree_sum + pair_count(v)) & 32'h7FFFFF;
      reach_sum = (reach_sum + (pair_count(n) - pair_count(n - v))) & 32'h7FFFFF;

      if (tally_pos + 1 < nc) begin
         tally_pos++;
         return;
      end

      grand_agree = add_saturated(grand_agree, agree_sum);
      grand_reach = add_saturated(grand_reach, reach_sum);
      quot = 0;
      if (reach_sum != 0) begin
         wide_agree = agree_sum;
         quot = (wide_agree << OVERLAP_FRAC) / reach_sum;
         if (quot > OVERLAP_ONE) quot = OVERLAP_ONE;
      end
      r.majority_valid = lead_seen;
      r.majority_index = lead_seen ? lead_class : 8'd0;
      r.voxel_intersection = 23'(agree_sum);
      r.voxel_union = 23'(reach_sum);
      r.voxel_overlap = 17'(quot);
      r.total_intersection = 48'(grand_agree);
      r.total_union = 48'(grand_reach);
      fused_q = {fused_q, r};
      clear_voxel();
   endtask

   task automatic apply_register(input logic [1:0] idx, input logic [8:0] value);
      case (idx)
         CSR_NUM_RATERS: begin
            raters_cfg = value[7:0];
         end
         CSR_NUM_CLASSES: begin
            classes_cfg = value;
         end
         CSR_CLEAR_TOTALS: begin
            if (value[0]) begin
               grand_agree = 0;
               grand_reach = 0;
            end
         end
         default: begin
            // Unknown indexes are ignored by the block.
         end
      endcase
   endtask

   function automatic void check_field(input string what, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      end
   endfunction

   // Compare one taken result word with the oldest expected voxel.
   task automatic check_result();
      result_type want;
      if (fused_q.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result word, expected none, actual index %0d union %0d",
                  $time, rsp_majority_index, rsp_voxel_union);
         return;
      end
      want = fused_q.pop_front();
      check_field("majority_valid", want.majority_valid, rsp_majority_valid);
      check_field("majority_index", want.majority_index, rsp_majority_index);
      check_field("voxel_intersection", want.voxel_intersection, rsp_voxel_intersection);
      check_field("voxel_union", want.voxel_union, rsp_voxel_union);
      check_field("voxel_overlap", want.voxel_overlap, rsp_voxel_overlap);
      check_field("total_intersection", want.total_intersection, rsp_total_intersection);
      check_field("total_union", want.total_union, rsp_total_union);
      voxels_checked++;
   endtask

   // Receiver: checks each taken word and chooses the stall for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_result();
      end
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   // Offer one vote word, after a random gap, and hold it until it is taken.
   task automatic send_vote(input logic [7:0] count);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vote_count <= count;
      do @(posedge clock); while (req_stall !== 1'b0);
      tally_vote(count);
      words_sent++;
   endtask

   // Stop sending, wait for every expected word and let the divider go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (fused_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      apply_register(idx, value);
      register_writes++;
      @(posedge clock);
   endtask

   task automatic effective_classes(output int unsigned nc);
      nc = classes_cfg;
      if (nc == 0) nc = 1;
      if (nc > MAX_CLASSES) nc = MAX_CLASSES;
   endtask

   // Reset settings: all-zero background, a tie, an overshooting count.
   task automatic test_reset_settings();
      logic [7:0] votes[12];
      votes = '{8'd0, 8'd0, 8'd0,
                8'd2, 8'd2, 8'd1,
                8'd1, 8'd255, 8'd0,
                8'd0, 8'd1, 8'd2};
      foreach (votes[i]) send_vote(votes[i]);
      settle();
   endtask

   // Zero raters, zero classes, full agreement, unknown index and clearing the totals.
   task automatic test_special_settings();
      write_register(CSR_NUM_RATERS, 9'd0);
      write_register(CSR_NUM_CLASSES, 9'd2);
      send_vote(8'd255);
      send_vote(8'd7);
      settle();
      write_register(CSR_UNUSED_INDEX, 9'h1FF);
      write_register(CSR_CLEAR_TOTALS, 9'd1);
      write_register(CSR_NUM_RATERS, 9'd255);
      write_register(CSR_NUM_CLASSES, 9'd0);
      send_vote(8'd255);
      send_vote(8'd128);
      send_vote(8'd0);
      settle();
      write_register(CSR_CLEAR_TOTALS, 9'd0);
      send_vote(8'd1);
      settle();
   endtask

   // The class count moves while a voxel is half done, both down and up.
   task automatic test_class_change_mid_voxel();
      write_register(CSR_NUM_RATERS, 9'd5);
      write_register(CSR_NUM_CLASSES, 9'd6);
      send_vote(8'd3);
      send_vote(8'd5);
      send_vote(8'd9);
      send_vote(8'd1);
      settle();
      write_register(CSR_NUM_CLASSES, 9'd3);
      send_vote(8'd2);
      send_vote(8'd1);
      send_vote(8'd4);
      settle();
      write_register(CSR_NUM_CLASSES, 9'd5);
      send_vote(8'd0);
      send_vote(8'd5);
      send_vote(8'd2);
      settle();
   endtask

   // Rounds of random settings, each with one or two voxels and sometimes a partial one.
   task automatic test_random_settings();
      int unsigned raters;
      int unsigned classes;
      int unsigned nc;
      int unsigned words;
      for (int round = 0; round < 12; round++) begin
         case (round % 4)
            0: raters = 1;
            1: raters = 255;
            2: raters = $urandom_range(2, 16);
            default: raters = $urandom_range(0, 255);
         endcase
         case (round % 3)
            0: classes = (round % 2 == 0) ? 0 : 1;
            default: classes = $urandom_range(2, 10);
         endcase
         settle();
         write_register(CSR_NUM_RATERS, 9'(raters));
         write_register(CSR_NUM_CLASSES, 9'(classes));
         if (round % 3 == 1) begin
            write_register(CSR_CLEAR_TOTALS, 9'($urandom_range(0, 1)));
         end
         effective_classes(nc);
         words = nc * $urandom_range(1, 2) + $urandom_range(0, 2);
         repeat (words) send_vote(vote_for(raters));
      end
      settle();
   endtask

   // One voxel at the widest class count, written above the maximum.
   task automatic test_widest_voxel();
      write_register(CSR_NUM_RATERS, 9'd255);
      write_register(CSR_NUM_CLASSES, 9'd511);
      // Any voxel left open by the earlier rounds runs on to the widest class count.
      repeat (MAX_CLASSES - tally_pos) send_vote(vote_for(255));
      settle();
   endtask

   // Receiver holds off while single-class voxels pour in, then the sender waits it out.
   task automatic test_backpressure();
      write_register(CSR_NUM_RATERS, 9'd255);
      write_register(CSR_NUM_CLASSES, 9'd1);
      idle_on = 1'b0;
      hold_request = 300;
      repeat (40) send_vote(8'($urandom_range(1, 255)));
      idle_on = 1'b1;
      settle();
      write_register(CSR_NUM_CLASSES, 9'd2);
      hold_request = 120;
      repeat (40) send_vote(vote_for(255));
      settle();
   endtask

   initial begin
      raters_cfg = RATERS_RESET;
      classes_cfg = CLASSES_RESET;
      grand_agree = 0;
      grand_reach = 0;
      clear_voxel();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_special_settings();
      test_class_change_mid_voxel();
      test_random_settings();
      test_widest_voxel();
      test_backpressure();
      settle();

      $display("Sent %0d vote words through %0d register writes; %0d voxels checked.",
               words_sent, register_writes, voxels_checked);
      $display("Covered zero and full rater counts, widest voxels and long output stalls.");
      if (mismatches == 0) begin
         $display("label_vote_fusion_overlap: match");
      end else begin
         $display("label_vote_fusion_overlap: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
